// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/tts_pkg.sv =====
// Types and constants of the template token scanner.
`timescale 1ns / 1ps

package tts_pkg;

   typedef enum logic [2:0] {
      MODE_NONE  = 3'd0,
      MODE_TEXT  = 3'd1,
      MODE_NAME  = 3'd2,
      MODE_PARAM = 3'd3,
      MODE_BLOCK = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      EV_TEXT_CHAR  = 3'd0,
      EV_NAME_CHAR  = 3'd1,
      EV_PARAM_CHAR = 3'd2,
      EV_BLOCK_CHAR = 3'd3,
      EV_TEXT_END   = 3'd4,
      EV_CMD_END    = 3'd5,
      EV_BLOCK_END  = 3'd6
   } event_type;

   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] char_value;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ===== sv/tts_classifier.sv =====
// Input register, scan state and byte classification into up to two results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tts_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              advance,
   output tts_pkg::push_type push
);

   logic               stage_valid_ff, stage_valid_in;
   logic [7:0]         stage_byte_ff, stage_byte_in;
   logic               stage_last_ff, stage_last_in;
   tts_pkg::mode_type  mode_ff, mode_in;
   logic               bs_ff, bs_in;
   logic               fire;
   logic               take;

   tts_pkg::mode_type  next_mode;
   logic               next_bs;
   logic [1:0]         n;
   logic [2:0]         ev0, ev1;
   logic [7:0]         ch0;

   assign fire       = stage_valid_ff && advance;
   assign req_tready = !stage_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = take ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);
      stage_byte_in  = take ? req_tdata : stage_byte_ff;
      stage_last_in  = take ? req_tlast : stage_last_ff;
   end

   // classification of the staged byte
   always_comb begin
      logic [7:0] c;
      logic       fin;
      logic       opener;
      logic       escaped;
      logic       keep;
      c         = stage_byte_ff;
      fin       = stage_last_ff;
      opener    = (c == tts_pkg::CHAR_LBRACE) || (c == tts_pkg::CHAR_LBRACKET);
      escaped   = (mode_ff == tts_pkg::MODE_TEXT) && bs_ff;
      keep      = (c != tts_pkg::CHAR_BACKSLASH) || fin;
      next_mode = mode_ff;
      next_bs   = bs_ff;
      n         = 2'd0;
      ev0       = tts_pkg::EV_TEXT_CHAR;
      ev1       = tts_pkg::EV_TEXT_END;
      ch0       = 8'h00;
      case (mode_ff)
         tts_pkg::MODE_NONE, tts_pkg::MODE_TEXT: begin
            if (opener && !escaped) begin
               next_bs   = 1'b0;
               next_mode = (c == tts_pkg::CHAR_LBRACKET) ? tts_pkg::MODE_BLOCK
                                                          : tts_pkg::MODE_NAME;
               if (mode_ff == tts_pkg::MODE_TEXT) begin
                  ev0 = tts_pkg::EV_TEXT_END;
                  ev1 = (c == tts_pkg::CHAR_LBRACKET) ? tts_pkg::EV_BLOCK_END
                                                       : tts_pkg::EV_CMD_END;
                  n   = fin ? 2'd2 : 2'd1;
               end else begin
                  ev0 = (c == tts_pkg::CHAR_LBRACKET) ? tts_pkg::EV_BLOCK_END
                                                       : tts_pkg::EV_CMD_END;
                  n   = fin ? 2'd1 : 2'd0;
               end
            end else begin
               next_mode = tts_pkg::MODE_TEXT;
               next_bs   = (c == tts_pkg::CHAR_BACKSLASH);
               if (keep) begin
                  ev0 = tts_pkg::EV_TEXT_CHAR;
                  ch0 = c;
                  ev1 = tts_pkg::EV_TEXT_END;
                  n   = fin ? 2'd2 : 2'd1;
               end
            end
         end
         tts_pkg::MODE_NAME, tts_pkg::MODE_PARAM: begin
            if (c == tts_pkg::CHAR_RBRACE) begin
               ev0       = tts_pkg::EV_CMD_END;
               n         = 2'd1;
               next_mode = tts_pkg::MODE_NONE;
            end else if (mode_ff == tts_pkg::MODE_NAME && c == tts_pkg::CHAR_SPACE) begin
               next_mode = tts_pkg::MODE_PARAM;
               ev0       = tts_pkg::EV_CMD_END;
               n         = fin ? 2'd1 : 2'd0;
            end else begin
               ev0 = (mode_ff == tts_pkg::MODE_NAME) ? tts_pkg::EV_NAME_CHAR
                                                      : tts_pkg::EV_PARAM_CHAR;
               ch0 = c;
               ev1 = tts_pkg::EV_CMD_END;
               n   = fin ? 2'd2 : 2'd1;
            end
         end
         tts_pkg::MODE_BLOCK: begin
            if (c == tts_pkg::CHAR_RBRACKET) begin
               ev0       = tts_pkg::EV_BLOCK_END;
               n         = 2'd1;
               next_mode = tts_pkg::MODE_NONE;
            end else begin
               ev0 = tts_pkg::EV_BLOCK_CHAR;
               ch0 = c;
               ev1 = tts_pkg::EV_BLOCK_END;
               n   = fin ? 2'd2 : 2'd1;
            end
         end
         default: begin
            next_mode = tts_pkg::MODE_NONE;
            next_bs   = 1'b0;
         end
      endcase
      if (fin) begin
         next_mode = tts_pkg::MODE_NONE;
         next_bs   = 1'b0;
      end
   end

   always_comb begin
      push.cnt           = fire ? n : 2'd0;
      push.r0.event_res  = ev0;
      push.r0.char_value = ch0;
      push.r0.last       = (n == 2'd1);
      push.r1.event_res  = ev1;
      push.r1.char_value = 8'h00;
      push.r1.last       = 1'b1;
      mode_in            = fire ? next_mode : mode_ff;
      bs_in              = fire ? next_bs : bs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         mode_ff        <= tts_pkg::MODE_NONE;
         bs_ff          <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         mode_ff        <= mode_in;
         bs_ff          <= bs_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
      stage_last_ff <= stage_last_in;
   end

   `ASSERT_PROP(a_bs_in_text, clock, reset, bs_ff |-> (mode_ff == tts_pkg::MODE_TEXT), "escape outside text")
   `ASSERT_PROP(a_fin_clears, clock, reset, (fire && stage_last_ff) |=> (mode_ff == tts_pkg::MODE_NONE && !bs_ff), "stream end left state")
   `ASSERT_PROP(a_fin_emits, clock, reset, (fire && stage_last_ff) |-> (push.cnt != 2'd0), "stream end without result")

endmodule

// ===== sv/tts_result_fifo.sv =====
// Four-entry result queue taking up to two results a cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tts_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  tts_pkg::push_type   push,
   input  logic                pop,
   output logic                head_valid,
   output tts_pkg::result_type head,
   output logic                space_ok
);

   tts_pkg::result_type               mem_ff [tts_pkg::FIFO_DEPTH];
   logic [tts_pkg::PTR_W-1:0]         wr_ff, wr_in;
   logic [tts_pkg::PTR_W-1:0]         rd_ff, rd_in;
   logic [tts_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                              do_pop;
   logic [tts_pkg::PTR_W-1:0]         wr_next;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   // room for a full pair whether or not the head drains
   assign space_ok   = (count_ff <= tts_pkg::CNT_W'(tts_pkg::FIFO_DEPTH - 2));
   assign do_pop     = pop && head_valid;
   assign wr_next    = wr_ff + tts_pkg::PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + tts_pkg::PTR_W'(push.cnt);
      rd_in    = rd_ff + tts_pkg::PTR_W'(do_pop);
      count_in = count_ff + tts_pkg::CNT_W'(push.cnt) - tts_pkg::CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   `ASSERT_NEVER(a_overflow, clock, reset, count_ff > tts_pkg::CNT_W'(tts_pkg::FIFO_DEPTH), "result queue overflow")
   `ASSERT_PROP(a_push_room, clock, reset, (push.cnt != 2'd0) |-> space_ok, "push without room")

endmodule

// ===== sv/template_token_scanner_core.sv =====
// A request is registered in the stage register, classified and written to
// the result queue, which offers its first result; the staged request waits
// while the queue lacks room. Throughput: one request per cycle while each
// request yields at most one result and the output is not stalled; the queue
// hides an isolated two-result request, back-to-back pairs hold input back.
// Reset: synchronous, active high; scan mode returns to between tokens, queue empties.
`timescale 1ns / 1ps

module template_token_scanner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] event_res, [10:3] char_value, [15:11] zero
   output logic        rsp_tlast    // last
);

   tts_pkg::push_type   push;
   tts_pkg::result_type head;
   logic                space_ok;

   tts_classifier u_classifier (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (space_ok),
      .push       (push)
   );

   tts_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .space_ok   (space_ok)
   );

   assign rsp_tdata = {5'b00000, head.char_value, head.event_res};
   assign rsp_tlast = head.last;

endmodule

// ===== tb/sv/template_token_scanner_checker.sv =====
// Checker for the template token scanner: predicts token events and compares them.
`timescale 1ns / 1ps

module template_token_scanner_checker
   import tts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_stream
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [2:0] event_res, [10:3] char_value, [15:11] zero
   input  logic        rsp_tlast,   // last
   output int          fail_count,
   output int          pending
);

   mode_type   scan_mode_q;
   logic       escape_q;
   result_type events_due[$];

   task automatic emit_event(input event_type ev, input logic [7:0] ch);
      result_type r;
      r.event_res  = ev;
      r.char_value = (ev <= EV_BLOCK_CHAR) ? ch : 8'h00;
      r.last       = 1'b0;
      events_due.push_back(r);
   endtask

   // Classify one byte and queue the events it gives.
   task automatic scan_byte(input logic [7:0] c, input logic fin);
      int       before_n;
      mode_type mode;
      logic     opener;
      before_n = events_due.size();
      mode     = scan_mode_q;
      if (mode == MODE_NONE || mode == MODE_TEXT) begin
         opener = (c == CHAR_LBRACE || c == CHAR_LBRACKET);
         if (opener && !(mode == MODE_TEXT && escape_q)) begin
            if (mode == MODE_TEXT) emit_event(EV_TEXT_END, 8'h00);
            escape_q = 1'b0;
            mode = (c == CHAR_LBRACKET) ? MODE_BLOCK : MODE_NAME;
            if (fin) emit_event((mode == MODE_BLOCK) ? EV_BLOCK_END : EV_CMD_END, 8'h00);
         end else begin
            mode = MODE_TEXT;
            if (c != CHAR_BACKSLASH || fin) emit_event(EV_TEXT_CHAR, c);
            escape_q = (c == CHAR_BACKSLASH);
            if (fin) emit_event(EV_TEXT_END, 8'h00);
         end
      end else if (mode == MODE_NAME || mode == MODE_PARAM) begin
         if (c == CHAR_RBRACE) begin
            emit_event(EV_CMD_END, 8'h00);
            mode = MODE_NONE;
         end else begin
            if (mode == MODE_NAME && c == CHAR_SPACE) mode = MODE_PARAM;
            else emit_event((mode == MODE_NAME) ? EV_NAME_CHAR : EV_PARAM_CHAR, c);
            if (fin) emit_event(EV_CMD_END, 8'h00);
         end
      end else begin
         if (c == CHAR_RBRACKET) begin
            emit_event(EV_BLOCK_END, 8'h00);
            mode = MODE_NONE;
         end else begin
            emit_event(EV_BLOCK_CHAR, c);
            if (fin) emit_event(EV_BLOCK_END, 8'h00);
         end
      end
      if (fin) begin
         mode     = MODE_NONE;
         escape_q = 1'b0;
      end
      scan_mode_q = mode;
      if (events_due.size() > before_n) events_due[events_due.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      int         errs;
      result_type want;
      errs = 0;
      if (reset) begin
         scan_mode_q = MODE_NONE;
         escape_q    = 1'b0;
         events_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (events_due.size() == 0) begin
               $error("unexpected result: event_res %0d char_value %0d last %0d",
                      rsp_tdata[2:0], rsp_tdata[10:3], rsp_tlast);
               errs++;
            end else begin
               want = events_due.pop_front();
               if (rsp_tdata[2:0] !== want.event_res) begin
                  $error("event_res: expected %0d, got %0d", want.event_res, rsp_tdata[2:0]);
                  errs++;
               end
               if (rsp_tdata[10:3] !== want.char_value) begin
                  $error("char_value: expected %0d, got %0d", want.char_value,
                         rsp_tdata[10:3]);
                  errs++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  errs++;
               end
               if (rsp_tdata[15:11] !== 5'd0) begin
                  $error("padding: expected 0, got %0d", rsp_tdata[15:11]);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         fail_count <= fail_count + errs;
      end
      pending <= events_due.size();
   end

endmodule

// ===== tb/sv/template_token_scanner_core_tb.sv =====
// Testbench top for the template token scanner: clock, reset, byte streams and verdict.
`timescale 1ns / 1ps

module template_token_scanner_core_tb;
   import tts_pkg::*;

   localparam int RANDOM_REQUESTS = 1650;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int STEADY_FROM     = 700;
   localparam int STEADY_TO       = 1000;

   // text, escapes, a command with params, empty block and command, nested openers,
   // and a final backslash
   localparam logic [7:0] OPENING_RUN[20] = '{
      8'h00, 8'hFF, CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_LBRACE, CHAR_LBRACE, 8'h6E,
      CHAR_SPACE, 8'h70, CHAR_BACKSLASH, CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET,
      CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET, CHAR_LBRACE, CHAR_BACKSLASH,
      CHAR_RBRACKET, CHAR_BACKSLASH
   };
   localparam logic [7:0] SPECIALS[6] = '{
      CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET, CHAR_SPACE, CHAR_BACKSLASH
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   bit          steady      = 1'b0;
   int          random_sent = 0;
   logic [7:0]  stream_q[$];

   template_token_scanner_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   template_token_scanner_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] value, input logic final_byte);
      if (!steady && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= final_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_request(stream_q[i], i == stream_q.size() - 1);
      stream_q.delete();
   endtask

   function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
      return v;
   endfunction

   // A run of text, command and block tokens, sometimes cut short.
   task automatic build_stream();
      int segments;
      int len;
      int cut;
      segments = $urandom_range(1, 6);
      for (int s = 0; s < segments; s++) begin
         case ($urandom_range(0, 2))
            0: begin
               len = $urandom_range(1, 8);
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 4) == 0) begin
                     stream_q.push_back(CHAR_BACKSLASH);
                     stream_q.push_back($urandom_range(0, 1) ? CHAR_LBRACE : CHAR_LBRACKET);
                  end else begin
                     stream_q.push_back(pick_byte(CHAR_LBRACE, CHAR_LBRACKET, CHAR_BACKSLASH));
                  end
               end
            end
            1: begin
               stream_q.push_back(CHAR_LBRACE);
               len = $urandom_range(0, 4);
               for (int k = 0; k < len; k++)
                  stream_q.push_back(pick_byte(CHAR_RBRACE, CHAR_SPACE, CHAR_RBRACE));
               if ($urandom_range(0, 2) != 0) begin
                  stream_q.push_back(CHAR_SPACE);
                  len = $urandom_range(0, 5);
                  for (int k = 0; k < len; k++)
                     stream_q.push_back(pick_byte(CHAR_RBRACE, CHAR_RBRACE, CHAR_RBRACE));
               end
               stream_q.push_back(CHAR_RBRACE);
            end
            default: begin
               stream_q.push_back(CHAR_LBRACKET);
               len = $urandom_range(0, 6);
               for (int k = 0; k < len; k++)
                  stream_q.push_back(pick_byte(CHAR_RBRACKET, CHAR_RBRACKET, CHAR_RBRACKET));
               stream_q.push_back(CHAR_RBRACKET);
            end
         endcase
      end
      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, stream_q.size());
         while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
   endtask

   initial begin
      int len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_RUN[i]) stream_q.push_back(OPENING_RUN[i]);
      send_stream();
      send_request(CHAR_LBRACE, 1'b1);
      send_request(CHAR_LBRACKET, 1'b1);
      send_request(8'h78, 1'b0);
      send_request(CHAR_LBRACKET, 1'b1);
      send_request(CHAR_LBRACE, 1'b0);
      send_request(8'h61, 1'b1);

      while (random_sent < RANDOM_REQUESTS) begin
         steady = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
         if ($urandom_range(0, 99) < 80) begin
            build_stream();
         end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 99) < 30) stream_q.push_back(SPECIALS[$urandom_range(0, 5)]);
               else stream_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         random_sent += stream_q.size();
         send_stream();
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
